>>> rtl/l2cc_pkg.sv
package l2cc_pkg;

    localparam int unsigned NUM_REGS = 26;
    localparam int unsigned SLOT_W   = $clog2(NUM_REGS);

    localparam logic [31:0] ID_WORD0 = 32'h410000C8;
    localparam logic [31:0] ID_WORD1 = 32'h1C100100;

    localparam logic [31:0] RST_AUX_CTRL = 32'h02020000;
    localparam logic [31:0] RST_LATENCY  = 32'h00000111;

    localparam logic [SLOT_W-1:0] SLOT_AUX      = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_TAG_LAT  = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_DATA_LAT = SLOT_W'(3);

    localparam logic       MODE_READ  = 1'b0;
    localparam logic       MODE_WRITE = 1'b1;
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [11:0] byte_offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
    } t_out_item;

    // Decode of one aligned word offset of the window.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              is_id0;
        logic              is_id1;
        logic              is_ctrl;
        logic              is_maint;
        logic              is_raw;
    } t_decode;

    function automatic t_decode l2cc_decode(input logic [11:0] ofs);
        t_decode d;
        d = '0;
        d.hit = 1'b1;
        unique case (ofs)
            12'h000: begin d.hit = 1'b0; d.is_id0 = 1'b1; end
            12'h004: begin d.hit = 1'b0; d.is_id1 = 1'b1; end
            12'h100: begin d.slot = SLOT_W'(0);  d.is_ctrl = 1'b1; end
            12'h104: d.slot = SLOT_W'(1);
            12'h108: d.slot = SLOT_W'(2);
            12'h10C: d.slot = SLOT_W'(3);
            12'h200: d.slot = SLOT_W'(4);
            12'h204: d.slot = SLOT_W'(5);
            12'h208: d.slot = SLOT_W'(6);
            12'h20C: d.slot = SLOT_W'(7);
            12'h210: d.slot = SLOT_W'(8);
            12'h214: d.slot = SLOT_W'(9);
            12'h218: d.slot = SLOT_W'(10);
            12'h21C: begin d.slot = SLOT_W'(11); d.is_raw = 1'b1; end
            12'h220: d.slot = SLOT_W'(12);
            12'h730: begin d.slot = SLOT_W'(13); d.is_maint = 1'b1; end
            12'h740: d.slot = SLOT_W'(14);
            12'h770: begin d.slot = SLOT_W'(15); d.is_maint = 1'b1; end
            12'h77C: begin d.slot = SLOT_W'(16); d.is_maint = 1'b1; end
            12'h7B0: begin d.slot = SLOT_W'(17); d.is_maint = 1'b1; end
            12'h7B8: begin d.slot = SLOT_W'(18); d.is_maint = 1'b1; end
            12'h7BC: begin d.slot = SLOT_W'(19); d.is_maint = 1'b1; end
            12'h7F0: begin d.slot = SLOT_W'(20); d.is_maint = 1'b1; end
            12'h7F8: begin d.slot = SLOT_W'(21); d.is_maint = 1'b1; end
            12'h7FC: begin d.slot = SLOT_W'(22); d.is_maint = 1'b1; end
            12'hF40: d.slot = SLOT_W'(23);
            12'hF60: d.slot = SLOT_W'(24);
            12'hF80: d.slot = SLOT_W'(25);
            default: d.hit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/l2_cache_ctrl_register_block.sv
// Register window of an L2 cache controller (no cached data). Each input transfer is one bus
// access and yields exactly one output transfer, in order. The block takes one access per
// cycle while its output is not stalled; the result passes first through the input register
// and then through the result register, with the register-file read-modify-write done
// combinationally between them. A stalled output holds its result while one more
// access can wait in the input register. Unknown offsets, misaligned word accesses and
// writes to the two ID words return access_error with zero read data and change nothing.
module l2_cache_ctrl_register_block (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  l2cc_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output l2cc_pkg::t_out_item o_out_data
);
    import l2cc_pkg::*;

    logic        r_s1_vld;
    t_in_item    r_s1;
    logic        r_out_vld;
    t_out_item   r_out;
    logic [31:0] r_regs [NUM_REGS];

    logic        out_free;
    logic        advance;
    t_decode     dec;
    logic        is_word;
    logic        misaligned;
    logic [4:0]  shift;
    logic [31:0] cur_word;
    logic [31:0] lane;
    logic [31:0] merged;
    logic [31:0] n_reg;
    logic        do_write;
    t_out_item   n_out;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;

    always_comb begin
        dec        = l2cc_decode({r_s1.byte_offset[11:2], 2'b00});
        is_word    = r_s1.access_size[1];
        misaligned = is_word && (r_s1.byte_offset[1:0] != 2'b00);
        shift      = {r_s1.byte_offset[1:0], 3'b000};

        priority if (dec.is_id0) begin
            cur_word = ID_WORD0;
        end else if (dec.is_id1) begin
            cur_word = ID_WORD1;
        end else begin
            cur_word = r_regs[dec.slot];
        end

        unique case (r_s1.access_size)
            SIZE_BYTE: lane = 32'h0000_00FF << shift;
            SIZE_HALF: lane = 32'h0000_FFFF << shift;
            default:   lane = '1;
        endcase

        merged = (cur_word & ~lane) | ((r_s1.write_data << shift) & lane);
        if (dec.is_ctrl) begin
            merged = merged & 32'h0000_0001;
        end

        priority if (dec.is_maint) begin
            n_reg = '0;
        end else if (dec.is_raw) begin
            n_reg = cur_word & ~(merged & lane);
        end else begin
            n_reg = merged;
        end

        n_out    = '0;
        do_write = 1'b0;
        if (r_s1.mode == MODE_WRITE) begin
            if (!dec.hit || misaligned) begin
                n_out.access_error = 1'b1;
            end else begin
                do_write = 1'b1;
            end
        end else begin
            if ((!dec.hit && !dec.is_id0 && !dec.is_id1) || misaligned) begin
                n_out.access_error = 1'b1;
            end else begin
                unique case (r_s1.access_size)
                    SIZE_BYTE: n_out.read_data = (cur_word >> shift) & 32'h0000_00FF;
                    SIZE_HALF: n_out.read_data =
                        (cur_word >> {r_s1.byte_offset[1], 4'b0000}) & 32'h0000_FFFF;
                    default:   n_out.read_data = cur_word;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_regs[SLOT_AUX]      <= RST_AUX_CTRL;
            r_regs[SLOT_TAG_LAT]  <= RST_LATENCY;
            r_regs[SLOT_DATA_LAT] <= RST_LATENCY;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_s1_vld <= 1'b1;
            end else if (advance) begin
                r_s1_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (advance && do_write) begin
                r_regs[dec.slot] <= n_reg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1 <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/l2cc_port_chk.sv
module l2cc_port_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input l2cc_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input l2cc_pkg::t_out_item o_out_data
);
    import l2cc_pkg::*;

    // The block only pushes back when its result register is full and blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output side can take a transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("pipeline not empty after reset");

    // A refused access never carries read data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.access_error) |-> (o_out_data.read_data == 32'h0))
        else $error("refused access returned nonzero data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transfer changed");

endmodule

bind l2_cache_ctrl_register_block l2cc_port_chk u_l2cc_port_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
